// ===== rtl/core/mlfq_three_level_scheduler_top_assert.svh =====
// Assertion macros for the scheduler checker.
// Depends on a clock and reset signal in the scope of use.
`ifndef MLFQ_THREE_LEVEL_SCHEDULER_TOP_ASSERT_SVH
`define MLFQ_THREE_LEVEL_SCHEDULER_TOP_ASSERT_SVH

// plain property, checked at every edge outside reset
`define MLFQ_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// implication into the next cycle
`define MLFQ_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/core/mlfq_pkg.sv =====
// Shared types, codes and reset constants for the three-level scheduler.
// No dependencies.
package mlfq_pkg;

   localparam int TASK_COUNT_DEF = 16;
   localparam int LEVELS         = 3;
   localparam int ITEM_Q_DEPTH   = 2;

   localparam logic [7:0]  QUANTUM_ONE_RST    = 8'd2;
   localparam logic [7:0]  QUANTUM_TWO_RST    = 8'd4;
   localparam logic [7:0]  QUANTUM_THREE_RST  = 8'd8;
   localparam int          BOOST_PERIOD_RST   = 25;
   localparam logic [7:0]  BOOST_CAP_RST      = 8'd2;
   localparam logic [15:0] PHASE_RST          = 16'(1 % BOOST_PERIOD_RST);
   localparam logic [23:0] MASK24             = 24'hFFFFFF;

   localparam logic [2:0] CSR_QUANTUM_ONE    = 3'd0;
   localparam logic [2:0] CSR_QUANTUM_TWO    = 3'd1;
   localparam logic [2:0] CSR_QUANTUM_THREE  = 3'd2;
   localparam logic [2:0] CSR_BOOST_PERIOD   = 3'd3;
   localparam logic [2:0] CSR_BOOST_CAP      = 3'd4;

   typedef enum logic [1:0] {
      KIND_CREATE = 2'd0,
      KIND_BURST  = 2'd1,
      KIND_EXIT   = 2'd2,
      KIND_TICK   = 2'd3
   } kind_type;

   typedef enum logic [2:0] {
      RPT_CREATED = 3'd0,
      RPT_QUEUED  = 3'd1,
      RPT_EXIT    = 3'd2,
      RPT_RAN     = 3'd3,
      RPT_IDLE    = 3'd4
   } report_type;

   typedef enum logic [4:0] {
      B_IDLE,
      B_EV_EXEC,
      B_BST_RUN_RD,
      B_BST_RUN_WR,
      B_BST_POP,
      B_BST_FRD,
      B_BST_REC,
      B_BST_CAP,
      B_SCH_RD,
      B_SCH_DEC,
      B_SF_POP,
      B_SF_FRD,
      B_SF_REC,
      B_WAIT_SCAN,
      B_WAIT_WR,
      B_RUN_RD,
      B_RUN_EXEC
   } back_state_type;

   typedef struct packed {
      kind_type    kind;
      logic [4:0]  num;
      logic [15:0] blen;
   } item_type;

   typedef struct packed {
      logic [7:0]  quantum_one;
      logic [7:0]  quantum_two;
      logic [7:0]  quantum_three;
      logic [15:0] boost_period;
      logic [7:0]  boost_cap;
   } cfg_type;

   typedef struct packed {
      logic [1:0]  level;
      logic [15:0] burst;
      logic [15:0] remaining;
      logic [23:0] exec_total;
      logic [23:0] wait_total;
   } rec_type;

   typedef struct packed {
      logic        valid;
      report_type  report;
      logic [4:0]  task_out;
      logic [15:0] requested;
      logic [15:0] used;
      logic [1:0]  level;
      logic        boosted;
      logic [23:0] wait_total;
      logic [23:0] turnaround;
   } rsp_type;

   typedef struct packed {
      logic        done;
      logic [15:0] remainder;
   } div_rsp_type;

endpackage

// ===== rtl/core/mlfq_front.sv =====
// Front end: accepts transactions and drops event items with bad task numbers.
// Depends on mlfq_pkg.
module mlfq_front #(
   parameter int TASK_COUNT = mlfq_pkg::TASK_COUNT_DEF
) (
   input  logic               start,
   input  logic [1:0]         kind,
   input  logic [4:0]         task_number,
   input  logic [15:0]        burst_length,
   input  logic               q_full,
   input  logic               div_busy,
   output logic               busy,
   output logic               push,
   output mlfq_pkg::item_type item
);

   logic num_ok;

   assign busy   = q_full | div_busy;
   assign num_ok = (task_number != 5'd0) && (32'(task_number) <= 32'(TASK_COUNT));

   always_comb begin
      item.kind = mlfq_pkg::kind_type'(kind);
      item.num  = task_number;
      item.blen = burst_length;
      push      = start && !busy && ((item.kind == mlfq_pkg::KIND_TICK) || num_ok);
   end

endmodule

// ===== rtl/core/mlfq_item_fifo.sv =====
// Short item queue between the front end and the scheduler engine.
// Depends on mlfq_pkg.
module mlfq_item_fifo (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  mlfq_pkg::item_type push_item,
   input  logic               pop,
   output logic               valid,
   output logic               full,
   output mlfq_pkg::item_type head_item
);

   localparam int DEPTH = mlfq_pkg::ITEM_Q_DEPTH;
   localparam int PW    = $clog2(DEPTH);
   localparam int CW    = $clog2(DEPTH + 1);

   mlfq_pkg::item_type slot_ff [DEPTH];
   logic [PW-1:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0] count_ff, count_in;
   logic          do_push, do_pop;

   assign valid     = (count_ff != '0);
   assign full      = (count_ff == CW'(DEPTH));
   assign head_item = slot_ff[rd_ptr_ff];
   assign do_push   = push && !full;
   assign do_pop    = pop && valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

// ===== rtl/core/mlfq_rem_unit.sv =====
// Restoring remainder unit, one quotient bit per cycle.
// Used to realign the boost phase when the boost interval is written.
module mlfq_rem_unit (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic [31:0]           dividend,
   input  logic [15:0]           divisor,
   output logic                  busy,
   output mlfq_pkg::div_rsp_type rsp
);

   logic [31:0] dvd_ff, dvd_in;
   logic [15:0] rem_ff, rem_in, dsr_ff, dsr_in;
   logic [4:0]  cnt_ff, cnt_in;
   logic        busy_ff, busy_in, done_ff, done_in;
   logic [16:0] trial;

   assign busy          = busy_ff;
   assign rsp.done      = done_ff;
   assign rsp.remainder = rem_ff;

   always_comb begin
      trial   = {rem_ff, dvd_ff[31]};
      dvd_in  = dvd_ff;
      rem_in  = rem_ff;
      dsr_in  = dsr_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         dvd_in  = dividend;
         dsr_in  = divisor;
         rem_in  = '0;
         cnt_in  = '1;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         dvd_in = {dvd_ff[30:0], 1'b0};
         rem_in = (trial >= {1'b0, dsr_ff}) ? 16'(trial - {1'b0, dsr_ff}) : trial[15:0];
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      dvd_ff <= dvd_in;
      rem_ff <= rem_in;
      dsr_ff <= dsr_in;
      cnt_ff <= cnt_in;
   end

endmodule

// ===== rtl/core/mlfq_back.sv =====
// Scheduler engine: per-task record memory, level FIFOs and the tick sequencer.
// Depends on mlfq_pkg.
module mlfq_back #(
   parameter int TASK_COUNT = mlfq_pkg::TASK_COUNT_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  mlfq_pkg::cfg_type     cfg,
   input  logic                  q_valid,
   input  mlfq_pkg::item_type    q_item,
   output logic                  q_pop,
   input  mlfq_pkg::div_rsp_type div_rsp,
   output logic [31:0]           tick_count,
   output mlfq_pkg::rsp_type     rsp
);

   localparam int IW  = $clog2(TASK_COUNT);
   localparam int CW  = $clog2(TASK_COUNT + 1);
   localparam int FD  = mlfq_pkg::LEVELS * TASK_COUNT;
   localparam int FAW = $clog2(FD);
   localparam logic [CW-1:0] FULL = CW'(TASK_COUNT);
   localparam logic [IW-1:0] LAST = IW'(TASK_COUNT - 1);

   mlfq_pkg::back_state_type state_ff, state_in;
   mlfq_pkg::item_type       item_ff, item_in;
   mlfq_pkg::rsp_type        rsp_ff, rsp_in;
   mlfq_pkg::rec_type        rec_mem [TASK_COUNT];
   mlfq_pkg::rec_type        rec_rd_ff, rec_wr_data;
   logic [IW-1:0]            fifo_mem [FD];
   logic [IW-1:0]            fifo_rd_ff, fifo_wr_data;

   logic [TASK_COUNT-1:0] rec_vld_ff, rec_vld_in, queued_ff, queued_in;
   logic [IW-1:0] head_ff [mlfq_pkg::LEVELS];
   logic [IW-1:0] head_in [mlfq_pkg::LEVELS];
   logic [CW-1:0] count_ff [mlfq_pkg::LEVELS];
   logic [CW-1:0] count_in [mlfq_pkg::LEVELS];

   logic          boosted_ff, boosted_in, run_vld_ff, run_vld_in;
   logic [IW-1:0] run_idx_ff, run_idx_in, tmp_ff, tmp_in, scan_ff, scan_in;
   logic [1:0]    blvl_ff, blvl_in, sf_lvl_ff, sf_lvl_in;
   logic [7:0]    quant_ff, quant_in;
   logic [31:0]   tick_ff, tick_in;
   logic [15:0]   phase_ff, phase_in;

   logic           rec_rd_en, rec_wr_en, fifo_rd_en, fifo_wr_en;
   logic [IW-1:0]  rec_rd_addr, rec_wr_addr;
   logic [FAW-1:0] fifo_rd_addr, fifo_wr_addr;
   logic           push_en, pop_en;
   logic [1:0]     push_lvl, pop_lvl;
   logic [IW-1:0]  push_task;

   assign rsp        = rsp_ff;
   assign tick_count = tick_ff;

   function automatic logic [FAW-1:0] faddr(input logic [1:0] l, input logic [IW-1:0] p);
      return FAW'(l) * FAW'(TASK_COUNT) + FAW'(p);
   endfunction

   function automatic logic [1:0] lvl_index(input logic [1:0] l);
      logic [1:0] r;
      if (l == 2'd0) begin
         r = 2'd0;
      end else if (32'(l) > mlfq_pkg::LEVELS) begin
         r = 2'(mlfq_pkg::LEVELS - 1);
      end else begin
         r = l - 2'd1;
      end
      return r;
   endfunction

   function automatic logic [7:0] quantum_for(input mlfq_pkg::cfg_type c, input logic [1:0] l);
      logic [7:0] q;
      if (l <= 2'd1) begin
         q = c.quantum_one;
      end else if (l == 2'd2) begin
         q = c.quantum_two;
      end else begin
         q = c.quantum_three;
      end
      return q;
   endfunction

   function automatic logic [23:0] sat_inc(input logic [23:0] v);
      return (v == mlfq_pkg::MASK24) ? v : v + 24'd1;
   endfunction

   function automatic logic [IW-1:0] task_idx(input logic [4:0] num);
      return IW'(num - 5'd1);
   endfunction

   always_comb begin
      mlfq_pkg::rec_type wr;
      logic [1:0]        top, nl, nt;
      logic [15:0]       rem_new;
      logic [24:0]       tat;
      logic [IW-1:0]     t;
      logic [IW:0]       tsum;
      logic              boost, cond;

      state_in   = state_ff;
      item_in    = item_ff;
      boosted_in = boosted_ff;
      run_vld_in = run_vld_ff;
      run_idx_in = run_idx_ff;
      tmp_in     = tmp_ff;
      scan_in    = scan_ff;
      blvl_in    = blvl_ff;
      sf_lvl_in  = sf_lvl_ff;
      quant_in   = quant_ff;
      tick_in    = tick_ff;
      phase_in   = phase_ff;
      head_in    = head_ff;
      count_in   = count_ff;
      queued_in  = queued_ff;
      rec_vld_in = rec_vld_ff;
      rsp_in     = '0;
      q_pop      = 1'b0;
      rec_rd_en  = 1'b0;
      rec_rd_addr = run_idx_ff;
      rec_wr_en  = 1'b0;
      rec_wr_addr = run_idx_ff;
      rec_wr_data = rec_rd_ff;
      fifo_rd_en = 1'b0;
      fifo_rd_addr = faddr(sf_lvl_ff, head_ff[sf_lvl_ff]);
      fifo_wr_en = 1'b0;
      fifo_wr_addr = '0;
      fifo_wr_data = '0;
      push_en    = 1'b0;
      push_lvl   = 2'd0;
      push_task  = run_idx_ff;
      pop_en     = 1'b0;
      pop_lvl    = sf_lvl_ff;
      wr         = rec_rd_ff;
      nl         = 2'd0;
      nt         = 2'd0;
      rem_new    = 16'd0;
      tat        = '0;
      cond       = 1'b0;
      t          = task_idx(item_ff.num);
      tsum       = '0;
      boost      = (cfg.boost_period != 16'd0) && (phase_ff == 16'd0);

      if (count_ff[0] != '0) begin
         top = 2'd1;
      end else if (count_ff[1] != '0) begin
         top = 2'd2;
      end else if (count_ff[2] != '0) begin
         top = 2'd3;
      end else begin
         top = 2'd0;
      end

      unique case (state_ff)
         mlfq_pkg::B_IDLE: begin
            if (q_valid) begin
               q_pop   = 1'b1;
               item_in = q_item;
               if (q_item.kind == mlfq_pkg::KIND_TICK) begin
                  boosted_in = boost;
                  blvl_in    = 2'd2;
                  if (boost) begin
                     state_in = run_vld_ff ? mlfq_pkg::B_BST_RUN_RD : mlfq_pkg::B_BST_POP;
                  end else begin
                     state_in = mlfq_pkg::B_SCH_RD;
                  end
               end else begin
                  rec_rd_en   = 1'b1;
                  rec_rd_addr = task_idx(q_item.num);
                  state_in    = mlfq_pkg::B_EV_EXEC;
               end
            end
         end
         mlfq_pkg::B_EV_EXEC: begin
            rsp_in.valid    = 1'b1;
            rsp_in.task_out = item_ff.num;
            unique case (item_ff.kind)
               mlfq_pkg::KIND_BURST: begin
                  rsp_in.report = mlfq_pkg::RPT_QUEUED;
                  wr.burst      = item_ff.blen;
                  wr.remaining  = item_ff.blen;
                  cond = !(run_vld_ff && (run_idx_ff == t)) && !queued_ff[t] &&
                         (item_ff.blen != 16'd0);
                  if (cond) begin
                     if (wr.level == 2'd0) begin
                        wr.level = 2'd1;
                     end
                     push_en   = 1'b1;
                     push_lvl  = lvl_index(wr.level);
                     push_task = t;
                  end
                  rec_wr_en   = 1'b1;
                  rec_wr_addr = t;
                  rec_wr_data = wr;
               end
               mlfq_pkg::KIND_EXIT: begin
                  tat = {1'b0, rec_rd_ff.exec_total} + {1'b0, rec_rd_ff.wait_total};
                  rsp_in.report     = mlfq_pkg::RPT_EXIT;
                  rsp_in.wait_total = rec_rd_ff.wait_total;
                  rsp_in.turnaround = tat[24] ? mlfq_pkg::MASK24 : tat[23:0];
               end
               default: begin
                  rsp_in.report = mlfq_pkg::RPT_CREATED;
               end
            endcase
            state_in = mlfq_pkg::B_IDLE;
         end
         mlfq_pkg::B_BST_RUN_RD: begin
            rec_rd_en   = 1'b1;
            rec_rd_addr = run_idx_ff;
            state_in    = mlfq_pkg::B_BST_RUN_WR;
         end
         mlfq_pkg::B_BST_RUN_WR: begin
            wr.level    = 2'd1;
            rec_wr_en   = 1'b1;
            rec_wr_addr = run_idx_ff;
            rec_wr_data = wr;
            state_in    = mlfq_pkg::B_BST_POP;
         end
         mlfq_pkg::B_BST_POP: begin
            if (count_ff[blvl_ff] != '0) begin
               fifo_rd_en   = 1'b1;
               fifo_rd_addr = faddr(blvl_ff, head_ff[blvl_ff]);
               state_in     = mlfq_pkg::B_BST_FRD;
            end else if (blvl_ff == 2'd2) begin
               blvl_in = 2'd1;
            end else begin
               state_in = mlfq_pkg::B_BST_CAP;
            end
         end
         mlfq_pkg::B_BST_FRD: begin
            pop_en      = 1'b1;
            pop_lvl     = blvl_ff;
            tmp_in      = fifo_rd_ff;
            rec_rd_en   = 1'b1;
            rec_rd_addr = fifo_rd_ff;
            state_in    = mlfq_pkg::B_BST_REC;
         end
         mlfq_pkg::B_BST_REC: begin
            wr.level    = 2'd1;
            rec_wr_en   = 1'b1;
            rec_wr_addr = tmp_ff;
            rec_wr_data = wr;
            push_en     = 1'b1;
            push_lvl    = 2'd0;
            push_task   = tmp_ff;
            state_in    = mlfq_pkg::B_BST_POP;
         end
         mlfq_pkg::B_BST_CAP: begin
            if (quant_ff > cfg.boost_cap) begin
               quant_in = cfg.boost_cap;
            end
            state_in = mlfq_pkg::B_SCH_RD;
         end
         mlfq_pkg::B_SCH_RD: begin
            if (run_vld_ff) begin
               rec_rd_en   = 1'b1;
               rec_rd_addr = run_idx_ff;
               state_in    = mlfq_pkg::B_SCH_DEC;
            end else if (top != 2'd0) begin
               sf_lvl_in = top - 2'd1;
               state_in  = mlfq_pkg::B_SF_POP;
            end else begin
               scan_in  = '0;
               state_in = mlfq_pkg::B_WAIT_SCAN;
            end
         end
         mlfq_pkg::B_SCH_DEC: begin
            scan_in  = '0;
            state_in = mlfq_pkg::B_WAIT_SCAN;
            if (rec_rd_ff.remaining != 16'd0) begin
               if (quant_ff != 8'd0) begin
                  if ((top != 2'd0) && (top < rec_rd_ff.level)) begin
                     push_en   = 1'b1;
                     push_lvl  = lvl_index(rec_rd_ff.level);
                     sf_lvl_in = top - 2'd1;
                     state_in  = mlfq_pkg::B_SF_POP;
                  end
               end else begin
                  nl = (rec_rd_ff.level < 2'd3) ? rec_rd_ff.level + 2'd1 : rec_rd_ff.level;
                  wr.level    = nl;
                  rec_wr_en   = 1'b1;
                  rec_wr_addr = run_idx_ff;
                  rec_wr_data = wr;
                  push_en     = 1'b1;
                  push_lvl    = lvl_index(nl);
                  nt = ((top != 2'd0) && (top < nl)) ? top : nl;
                  sf_lvl_in   = lvl_index(nt);
                  state_in    = mlfq_pkg::B_SF_POP;
               end
            end else if (top != 2'd0) begin
               sf_lvl_in = top - 2'd1;
               state_in  = mlfq_pkg::B_SF_POP;
            end else begin
               run_vld_in = 1'b0;
            end
         end
         mlfq_pkg::B_SF_POP: begin
            fifo_rd_en   = 1'b1;
            fifo_rd_addr = faddr(sf_lvl_ff, head_ff[sf_lvl_ff]);
            state_in     = mlfq_pkg::B_SF_FRD;
         end
         mlfq_pkg::B_SF_FRD: begin
            pop_en      = 1'b1;
            pop_lvl     = sf_lvl_ff;
            run_vld_in  = 1'b1;
            run_idx_in  = fifo_rd_ff;
            rec_rd_en   = 1'b1;
            rec_rd_addr = fifo_rd_ff;
            state_in    = mlfq_pkg::B_SF_REC;
         end
         mlfq_pkg::B_SF_REC: begin
            quant_in = quantum_for(cfg, rec_rd_ff.level);
            scan_in  = '0;
            state_in = mlfq_pkg::B_WAIT_SCAN;
         end
         mlfq_pkg::B_WAIT_SCAN: begin
            if (queued_ff[scan_ff]) begin
               rec_rd_en   = 1'b1;
               rec_rd_addr = scan_ff;
               state_in    = mlfq_pkg::B_WAIT_WR;
            end else if (scan_ff == LAST) begin
               state_in = mlfq_pkg::B_RUN_RD;
            end else begin
               scan_in = scan_ff + 1'b1;
            end
         end
         mlfq_pkg::B_WAIT_WR: begin
            wr.wait_total = sat_inc(rec_rd_ff.wait_total);
            rec_wr_en     = 1'b1;
            rec_wr_addr   = scan_ff;
            rec_wr_data   = wr;
            if (scan_ff == LAST) begin
               state_in = mlfq_pkg::B_RUN_RD;
            end else begin
               scan_in  = scan_ff + 1'b1;
               state_in = mlfq_pkg::B_WAIT_SCAN;
            end
         end
         mlfq_pkg::B_RUN_RD: begin
            if (run_vld_ff) begin
               rec_rd_en   = 1'b1;
               rec_rd_addr = run_idx_ff;
               state_in    = mlfq_pkg::B_RUN_EXEC;
            end else begin
               rsp_in.valid   = 1'b1;
               rsp_in.report  = mlfq_pkg::RPT_IDLE;
               rsp_in.boosted = boosted_ff;
               state_in       = mlfq_pkg::B_IDLE;
            end
         end
         mlfq_pkg::B_RUN_EXEC: begin
            rem_new = (rec_rd_ff.remaining != 16'd0) ? rec_rd_ff.remaining - 16'd1 : 16'd0;
            wr.exec_total = sat_inc(rec_rd_ff.exec_total);
            wr.remaining  = rem_new;
            rec_wr_en     = 1'b1;
            rec_wr_addr   = run_idx_ff;
            rec_wr_data   = wr;
            if (quant_ff != 8'd0) begin
               quant_in = quant_ff - 8'd1;
            end
            rsp_in.valid     = 1'b1;
            rsp_in.report    = mlfq_pkg::RPT_RAN;
            rsp_in.task_out  = 5'({1'b0, run_idx_ff} + 1'b1);
            rsp_in.requested = rec_rd_ff.burst;
            rsp_in.used      = rec_rd_ff.burst - rem_new;
            rsp_in.level     = rec_rd_ff.level;
            rsp_in.boosted   = boosted_ff;
            if (rem_new == 16'd0) begin
               run_vld_in = 1'b0;
            end
            state_in = mlfq_pkg::B_IDLE;
         end
         default: begin
            state_in = mlfq_pkg::B_IDLE;
         end
      endcase

      // tick bookkeeping once the tick result goes out
      if (rsp_in.valid && (item_ff.kind == mlfq_pkg::KIND_TICK) &&
          (state_ff != mlfq_pkg::B_EV_EXEC)) begin
         if (tick_ff != '1) begin
            tick_in  = tick_ff + 32'd1;
            phase_in = ({1'b0, phase_ff} + 17'd1 >= {1'b0, cfg.boost_period}) ?
                       16'd0 : phase_ff + 16'd1;
         end
      end
      if (div_rsp.done) begin
         phase_in = div_rsp.remainder;
      end

      if (pop_en) begin
         head_in[pop_lvl]      = (head_ff[pop_lvl] == LAST) ? '0 : head_ff[pop_lvl] + 1'b1;
         count_in[pop_lvl]     = count_ff[pop_lvl] - 1'b1;
         queued_in[fifo_rd_ff] = 1'b0;
      end
      if (push_en && (count_ff[push_lvl] < FULL)) begin
         tsum = {1'b0, head_ff[push_lvl]} + (IW + 1)'(count_ff[push_lvl]);
         if (tsum >= (IW + 1)'(TASK_COUNT)) begin
            tsum = tsum - (IW + 1)'(TASK_COUNT);
         end
         fifo_wr_en           = 1'b1;
         fifo_wr_addr         = faddr(push_lvl, IW'(tsum));
         fifo_wr_data         = push_task;
         count_in[push_lvl]   = count_ff[push_lvl] + 1'b1;
         queued_in[push_task] = 1'b1;
      end
      if (rec_wr_en) begin
         rec_vld_in[rec_wr_addr] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= mlfq_pkg::B_IDLE;
         run_vld_ff <= 1'b0;
         run_idx_ff <= '0;
         quant_ff   <= 8'd0;
         tick_ff    <= 32'd1;
         phase_ff   <= mlfq_pkg::PHASE_RST;
         queued_ff  <= '0;
         rec_vld_ff <= '0;
         rsp_ff.valid <= 1'b0;
         for (int i = 0; i < mlfq_pkg::LEVELS; i++) begin
            head_ff[i]  <= '0;
            count_ff[i] <= '0;
         end
      end else begin
         state_ff   <= state_in;
         run_vld_ff <= run_vld_in;
         run_idx_ff <= run_idx_in;
         quant_ff   <= quant_in;
         tick_ff    <= tick_in;
         phase_ff   <= phase_in;
         queued_ff  <= queued_in;
         rec_vld_ff <= rec_vld_in;
         head_ff    <= head_in;
         count_ff   <= count_in;
         rsp_ff     <= rsp_in;
      end
      item_ff    <= item_in;
      boosted_ff <= boosted_in;
      tmp_ff     <= tmp_in;
      scan_ff    <= scan_in;
      blvl_ff    <= blvl_in;
      sf_lvl_ff  <= sf_lvl_in;
   end

   always_ff @(posedge clock) begin
      if (rec_wr_en) begin
         rec_mem[rec_wr_addr] <= rec_wr_data;
      end
      if (rec_rd_en) begin
         rec_rd_ff <= rec_vld_ff[rec_rd_addr] ? rec_mem[rec_rd_addr] : '0;
      end
   end

   always_ff @(posedge clock) begin
      if (fifo_wr_en) begin
         fifo_mem[fifo_wr_addr] <= fifo_wr_data;
      end
      if (fifo_rd_en) begin
         fifo_rd_ff <= fifo_mem[fifo_rd_addr];
      end
   end

endmodule

// ===== rtl/core/mlfq_three_level_scheduler_top.sv =====
// Three-level feedback queue scheduler with priority boost, top level.
// Depends on mlfq_pkg, mlfq_front, mlfq_item_fifo, mlfq_rem_unit, mlfq_back.
//
// Usage: drive req_kind/req_task_number/req_burst_length with start high;
// the transaction is taken at an edge where busy is low. Each accepted
// transaction gives one result on the rsp_ ports, flagged by rsp_valid for
// exactly one cycle; the receiver cannot stall. Create, burst or exit with
// a task number outside 1..TASK_COUNT is dropped and gives no result.
// A tick may first boost: the running task and every queued task go to the
// top level and the quantum is capped. It then picks the task to run, walks
// the task record memory to add one to the wait count of each queued task,
// and runs the chosen task, if any, for one unit of its burst. Items are
// carried out one at a time; a two-entry item queue lets up to two
// transactions be taken ahead. Writing a nonzero boost period realigns the
// boost phase with a remainder unit; busy stays high meanwhile.
// Reset (synchronous): empties all queues, clears task records through
// per-task valid bits, loads default registers; no clearing pass.
module mlfq_three_level_scheduler_top #(
   parameter int TASK_COUNT = mlfq_pkg::TASK_COUNT_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [1:0]  req_kind,
   input  logic [4:0]  req_task_number,
   input  logic [15:0] req_burst_length,
   output logic        rsp_valid,
   output logic [2:0]  rsp_report,
   output logic [4:0]  rsp_task_out,
   output logic [15:0] rsp_requested,
   output logic [15:0] rsp_used,
   output logic [1:0]  rsp_level,
   output logic        rsp_boosted,
   output logic [23:0] rsp_wait_total,
   output logic [23:0] rsp_turnaround,
   input  logic        csr_write_enable,
   input  logic [2:0]  csr_index,
   input  logic [15:0] csr_write_data
);

   mlfq_pkg::cfg_type     cfg_ff, cfg_in;
   mlfq_pkg::item_type    f_item, q_item;
   mlfq_pkg::rsp_type     rsp;
   mlfq_pkg::div_rsp_type div_rsp;
   logic        f_push, q_full, q_valid, q_pop, div_busy, div_start;
   logic [31:0] tick_count;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_enable) begin
         unique case (csr_index)
            mlfq_pkg::CSR_QUANTUM_ONE:    cfg_in.quantum_one    = csr_write_data[7:0];
            mlfq_pkg::CSR_QUANTUM_TWO:    cfg_in.quantum_two    = csr_write_data[7:0];
            mlfq_pkg::CSR_QUANTUM_THREE:  cfg_in.quantum_three  = csr_write_data[7:0];
            mlfq_pkg::CSR_BOOST_PERIOD:   cfg_in.boost_period   = csr_write_data;
            mlfq_pkg::CSR_BOOST_CAP:      cfg_in.boost_cap      = csr_write_data[7:0];
            default: ;
         endcase
      end
   end

   assign div_start = csr_write_enable && (csr_index == mlfq_pkg::CSR_BOOST_PERIOD) &&
                      (csr_write_data != 16'd0);

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.quantum_one    <= mlfq_pkg::QUANTUM_ONE_RST;
         cfg_ff.quantum_two    <= mlfq_pkg::QUANTUM_TWO_RST;
         cfg_ff.quantum_three  <= mlfq_pkg::QUANTUM_THREE_RST;
         cfg_ff.boost_period   <= 16'(mlfq_pkg::BOOST_PERIOD_RST);
         cfg_ff.boost_cap      <= mlfq_pkg::BOOST_CAP_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   mlfq_front #(.TASK_COUNT(TASK_COUNT)) u_front (
      .start        (start),
      .kind         (req_kind),
      .task_number  (req_task_number),
      .burst_length (req_burst_length),
      .q_full       (q_full),
      .div_busy     (div_busy),
      .busy         (busy),
      .push         (f_push),
      .item         (f_item)
   );

   mlfq_item_fifo u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (f_push),
      .push_item (f_item),
      .pop       (q_pop),
      .valid     (q_valid),
      .full      (q_full),
      .head_item (q_item)
   );

   mlfq_rem_unit u_rem (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (tick_count),
      .divisor  (csr_write_data),
      .busy     (div_busy),
      .rsp      (div_rsp)
   );

   mlfq_back #(.TASK_COUNT(TASK_COUNT)) u_back (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .q_valid    (q_valid),
      .q_item     (q_item),
      .q_pop      (q_pop),
      .div_rsp    (div_rsp),
      .tick_count (tick_count),
      .rsp        (rsp)
   );

   assign rsp_valid      = rsp.valid;
   assign rsp_report     = rsp.report;
   assign rsp_task_out   = rsp.task_out;
   assign rsp_requested  = rsp.requested;
   assign rsp_used       = rsp.used;
   assign rsp_level      = rsp.level;
   assign rsp_boosted    = rsp.boosted;
   assign rsp_wait_total = rsp.wait_total;
   assign rsp_turnaround = rsp.turnaround;

endmodule

// ===== rtl/core/mlfq_three_level_scheduler_checker.sv =====
// Port-level checks on the scheduler result channel, bound to the top level.
// Depends on mlfq_pkg and mlfq_three_level_scheduler_top_assert.svh.
`include "mlfq_three_level_scheduler_top_assert.svh"

module mlfq_three_level_scheduler_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic [2:0]  rsp_report,
   input logic [4:0]  rsp_task_out,
   input logic [15:0] rsp_requested,
   input logic [15:0] rsp_used,
   input logic [1:0]  rsp_level,
   input logic [23:0] rsp_wait_total,
   input logic [23:0] rsp_turnaround
);

   `MLFQ_ASSERT_NEXT(a_no_back_to_back, rsp_valid, !rsp_valid, "results in adjacent cycles")
   `MLFQ_ASSERT(a_idle_fields, !(rsp_valid && (rsp_report == mlfq_pkg::RPT_IDLE)) || ((rsp_task_out == 5'd0) && (rsp_level == 2'd0)), "idle result carries a task")
   `MLFQ_ASSERT(a_exit_only_stats, !(rsp_valid && (rsp_report != mlfq_pkg::RPT_EXIT)) || ((rsp_wait_total == 24'd0) && (rsp_turnaround == 24'd0)), "stats outside exit")
   `MLFQ_ASSERT(a_ran_usage, !(rsp_valid && (rsp_report == mlfq_pkg::RPT_RAN)) || ((rsp_used <= rsp_requested) && (rsp_level != 2'd0)), "ran result inconsistent")

endmodule

bind mlfq_three_level_scheduler_top mlfq_three_level_scheduler_checker u_checker (
   .clock          (clock),
   .reset          (reset),
   .rsp_valid      (rsp_valid),
   .rsp_report     (rsp_report),
   .rsp_task_out   (rsp_task_out),
   .rsp_requested  (rsp_requested),
   .rsp_used       (rsp_used),
   .rsp_level      (rsp_level),
   .rsp_wait_total (rsp_wait_total),
   .rsp_turnaround (rsp_turnaround)
);
